>>> hdl/fdc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the flood duplicate cache.
// No dependencies; every other file imports this package.
package fdc_pkg;

    localparam int DEPTH     = 16;
    localparam int NODE_BITS = 8;
    localparam int MSG_BITS  = 8;
    localparam int SEQ_BITS  = 8;
    localparam int HOP_BITS  = 4;

    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_ADD   = 1'b1;

    // Command word as it arrives on the port.
    typedef struct packed {
        logic       cmd;
        logic [7:0] node_id;
        logic [7:0] msg_id;
        logic [7:0] seq_num;
        logic [3:0] ttl;
    } t_cmd_word;

    typedef struct packed {
        logic is_duplicate;
        logic ttl_refreshed;
    } t_result_word;

    // One stored header, at the configured field widths.
    typedef struct packed {
        logic [NODE_BITS-1:0] node;
        logic [MSG_BITS-1:0]  msg;
        logic [SEQ_BITS-1:0]  seq;
        logic [HOP_BITS-1:0]  hop;
    } t_entry;

    // Match status handed from the older cell to the newer one.
    typedef struct packed {
        logic hit;
        logic refresh;
        logic dup;
    } t_chain;

endpackage

>>> hdl/fdc_cell.sv
`timescale 1ns / 1ps
// One cache cell: a stored header with its valid bit and match logic.
// Depends on fdc_pkg.
module fdc_cell import fdc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  logic   i_check,
    input  t_entry i_key,
    input  t_entry i_newer_entry,
    input  logic   i_newer_valid,
    input  t_chain i_chain,
    output t_entry o_entry,
    output logic   o_valid,
    output t_chain o_chain
);

    logic   r_valid, n_valid;
    t_entry r_entry, n_entry;
    logic   match, win, refresh;

    assign match   = r_valid && (r_entry.node == i_key.node) &&
                     (r_entry.msg == i_key.msg) && (r_entry.seq == i_key.seq);
    // only the oldest matching cell decides
    assign win     = match && !i_chain.hit;
    assign refresh = i_key.hop > r_entry.hop;

    always_comb begin
        o_chain.hit = i_chain.hit | match;
        if (win) begin
            o_chain.refresh = refresh;
            o_chain.dup     = !refresh;
        end else begin
            o_chain.refresh = i_chain.refresh;
            o_chain.dup     = i_chain.dup;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_shift) begin
            // advance toward the older end
            n_valid = i_newer_valid;
            n_entry = i_newer_entry;
        end else if (i_check && win && refresh) begin
            n_entry.hop = i_key.hop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

>>> hdl/flood_duplicate_cache_unit.sv
`timescale 1ns / 1ps
// Top level of the flood duplicate cache: a row of fdc_cell instances.
// Depends on fdc_pkg and fdc_cell.
//
// The cache holds the last DEPTH added headers in a row of cells, newest in
// cell 0. An add word shifts every cell one place toward the old end and drops
// the oldest when the row is full; a check word compares all cells at once and
// the oldest match, found by a hit chain running from the old end to cell 0,
// decides the result and may take the larger hop count. One word is taken
// every cycle, so busy stays low; its result is registered and appears on
// o_result in the cycle after the word is taken, strobed by o_result_valid
// for that single cycle. The result cannot be held off and must be captured
// when strobed. The longest path is the per-cell compare plus the hit chain
// through all DEPTH cells. There is no clearing pass after reset.
module flood_duplicate_cache_unit import fdc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  t_cmd_word    i_cmd,
    output logic         o_result_valid,
    output t_result_word o_result
);

    logic         accept;
    logic         shift, check;
    t_entry       key;
    t_entry       cell_entry [DEPTH];
    logic         cell_valid [DEPTH];
    t_chain       chain      [DEPTH+1];
    logic         r_result_valid;
    t_result_word r_result, n_result;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign shift  = accept && (i_cmd.cmd == CMD_ADD);
    assign check  = accept && (i_cmd.cmd == CMD_CHECK);

    assign key.node = NODE_BITS'(i_cmd.node_id);
    assign key.msg  = MSG_BITS'(i_cmd.msg_id);
    assign key.seq  = SEQ_BITS'(i_cmd.seq_num);
    assign key.hop  = HOP_BITS'(i_cmd.ttl);

    assign chain[DEPTH] = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_entry newer_entry;
        logic   newer_valid;
        if (k == 0) begin : g_head
            assign newer_entry = key;
            assign newer_valid = 1'b1;
        end else begin : g_body
            assign newer_entry = cell_entry[k-1];
            assign newer_valid = cell_valid[k-1];
        end
        fdc_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_shift       (shift),
            .i_check       (check),
            .i_key         (key),
            .i_newer_entry (newer_entry),
            .i_newer_valid (newer_valid),
            .i_chain       (chain[k+1]),
            .o_entry       (cell_entry[k]),
            .o_valid       (cell_valid[k]),
            .o_chain       (chain[k])
        );
    end

    always_comb begin
        n_result = '0;
        if (i_cmd.cmd == CMD_CHECK) begin
            n_result.is_duplicate  = chain[0].dup;
            n_result.ttl_refreshed = chain[0].refresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= accept;
        end
        r_result <= n_result;
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

>>> hdl/fdc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for flood_duplicate_cache_unit, bound to the top level.
// Depends on fdc_pkg.
module fdc_checker import fdc_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         start,
    input logic         busy,
    input t_cmd_word    i_cmd,
    input logic         o_result_valid,
    input t_result_word o_result
);

    a_strobe_follows_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_result_valid)
        else $error("taken word produced no result strobe");

    a_no_spurious_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_result_valid)
        else $error("result strobe without a taken word");

    a_add_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.cmd == CMD_ADD)) |=>
        (!o_result.is_duplicate && !o_result.ttl_refreshed))
        else $error("add word returned a nonzero result");

    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_result.is_duplicate && o_result.ttl_refreshed))
        else $error("duplicate and refresh flagged together");

endmodule

bind flood_duplicate_cache_unit fdc_checker u_fdc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cmd          (i_cmd),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

>>> test/flood_duplicate_cache_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for flood_duplicate_cache_unit: directed and random
// add/check words with a cycle-accurate cache predictor. Depends on fdc_pkg.
module flood_duplicate_cache_unit_tb;
    import fdc_pkg::*;

    localparam int RANDOM_WORDS = 1900;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int SETTLE       = 4;

    typedef struct {
        t_cmd_word word;
        bit        drain;
    } t_feed;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    t_cmd_word    i_cmd = '0;
    logic         o_result_valid;
    t_result_word o_result;

    t_feed        feed_q[$];
    t_result_word pending_verdicts[$];
    t_cmd_word    add_hist[$];

    // Predicted cache contents, oldest at index 0.
    t_entry       cache_rows[DEPTH];
    int unsigned  cache_fill = 0;

    t_feed        next_feed;
    t_result_word seen_verdict;
    t_result_word new_verdict;
    bit           hold_off;
    int           words_sent = 0;
    int           words_taken = 0;
    int           words_queued = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           n_adds = 0;
    int           n_checks = 0;
    int           n_dups = 0;
    int           n_refresh = 0;

    flood_duplicate_cache_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    function automatic t_cmd_word make_word(logic cmd, logic [7:0] node, logic [7:0] msg,
                                            logic [7:0] seq, logic [3:0] ttl);
        t_cmd_word w;
        w.cmd     = cmd;
        w.node_id = node;
        w.msg_id  = msg;
        w.seq_num = seq;
        w.ttl     = ttl;
        return w;
    endfunction

    function automatic void queue_word(t_cmd_word w, bit drain = 1'b0);
        t_feed f;
        f.word  = w;
        f.drain = drain;
        feed_q.push_back(f);
        words_queued++;
        if (w.cmd == CMD_ADD) begin
            add_hist.push_back(w);
            if (add_hist.size() > DEPTH)
                void'(add_hist.pop_front());
        end
    endfunction

    // Apply one word to the predicted cache and return its verdict.
    function automatic t_result_word screen_header(t_cmd_word w);
        t_entry       hdr;
        t_result_word verdict;
        bit           found;
        hdr.node = w.node_id[NODE_BITS-1:0];
        hdr.msg  = w.msg_id[MSG_BITS-1:0];
        hdr.seq  = w.seq_num[SEQ_BITS-1:0];
        hdr.hop  = w.ttl[HOP_BITS-1:0];
        verdict  = '0;
        found    = 1'b0;
        if (w.cmd == CMD_ADD) begin
            if (cache_fill == DEPTH) begin
                for (int i = 0; i < DEPTH - 1; i++)
                    cache_rows[i] = cache_rows[i+1];
                cache_fill = DEPTH - 1;
            end
            cache_rows[cache_fill] = hdr;
            cache_fill++;
        end else begin
            // Only the oldest matching row decides.
            for (int i = 0; i < cache_fill && !found; i++) begin
                if (cache_rows[i].node == hdr.node && cache_rows[i].msg == hdr.msg &&
                    cache_rows[i].seq == hdr.seq) begin
                    found = 1'b1;
                    if (hdr.hop > cache_rows[i].hop) begin
                        cache_rows[i].hop     = hdr.hop;
                        verdict.ttl_refreshed = 1'b1;
                    end else begin
                        verdict.is_duplicate = 1'b1;
                    end
                end
            end
        end
        return verdict;
    endfunction

    // Driver: present the next word, hold it while busy.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // hold the word until busy drops
        end else begin
            hold_off = ($urandom_range(0, 99) < 15) && !(words_sent >= 600 && words_sent < 1000);
            if (feed_q.size() == 0) begin
                start <= 1'b0;
            end else if (feed_q[0].drain &&
                         (start || o_result_valid || pending_verdicts.size() != 0)) begin
                start <= 1'b0;
            end else if (hold_off) begin
                start <= 1'b0;
            end else begin
                next_feed = feed_q.pop_front();
                i_cmd     <= next_feed.word;
                start     <= 1'b1;
                words_sent++;
            end
        end
    end

    // Monitor: check strobed results, then predict for the word taken now.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid === 1'b1) begin
                if (pending_verdicts.size() == 0) begin
                    note_mismatch("result strobed with nothing outstanding");
                end else begin
                    seen_verdict = pending_verdicts.pop_front();
                    if (o_result.is_duplicate !== seen_verdict.is_duplicate)
                        note_mismatch($sformatf("is_duplicate got %b want %b",
                                      o_result.is_duplicate, seen_verdict.is_duplicate));
                    if (o_result.ttl_refreshed !== seen_verdict.ttl_refreshed)
                        note_mismatch($sformatf("ttl_refreshed got %b want %b",
                                      o_result.ttl_refreshed, seen_verdict.ttl_refreshed));
                end
            end
            if (start && !busy) begin
                new_verdict = screen_header(i_cmd);
                pending_verdicts.push_back(new_verdict);
                words_taken++;
                if (i_cmd.cmd == CMD_ADD) n_adds++;
                else n_checks++;
                if (new_verdict.is_duplicate) n_dups++;
                if (new_verdict.ttl_refreshed) n_refresh++;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words taken", cycle_count, words_taken);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_cmd_word  w;
        t_cmd_word  pick;
        logic       cmd;
        int         roll;
        int         shape;

        // Directed: empty cache, extremes, refresh, oldest-match priority.
        queue_word(make_word(CMD_CHECK, 8'hff, 8'hff, 8'hff, 4'hf));
        queue_word(make_word(CMD_ADD,   8'h00, 8'h00, 8'h00, 4'h0));
        queue_word(make_word(CMD_ADD,   8'hff, 8'hff, 8'hff, 4'hf));
        queue_word(make_word(CMD_CHECK, 8'h00, 8'h00, 8'h00, 4'h0));
        queue_word(make_word(CMD_CHECK, 8'hff, 8'hff, 8'hff, 4'h5));
        queue_word(make_word(CMD_CHECK, 8'h00, 8'h00, 8'h00, 4'h7));
        queue_word(make_word(CMD_ADD,   8'h00, 8'h00, 8'h00, 4'h2));
        queue_word(make_word(CMD_CHECK, 8'h00, 8'h00, 8'h00, 4'h8));
        queue_word(make_word(CMD_CHECK, 8'h00, 8'h00, 8'h00, 4'h3));
        queue_word(make_word(CMD_CHECK, 8'h00, 8'h00, 8'h01, 4'hf));
        queue_word(make_word(CMD_CHECK, 8'h01, 8'h80, 8'h00, 4'hf));
        // Overflow the store so the oldest row drops out.
        for (int i = 0; i < 14; i++)
            queue_word(make_word(CMD_ADD, 8'(i + 16), 8'(8'ha5 ^ i), 8'(i * 3), 4'(i)));
        queue_word(make_word(CMD_CHECK, 8'h00, 8'h00, 8'h00, 4'h1));

        // Random: checks mostly reuse headers already added; some narrow collisions, some noise.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            roll  = $urandom_range(0, 99);
            shape = $urandom_range(0, 99);
            cmd   = (roll < 35) ? CMD_ADD : CMD_CHECK;
            w     = make_word(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            if (add_hist.size() != 0 && shape < ((cmd == CMD_ADD) ? 25 : 60)) begin
                pick      = add_hist[$urandom_range(0, add_hist.size() - 1)];
                w.node_id = pick.node_id;
                w.msg_id  = pick.msg_id;
                w.seq_num = pick.seq_num;
            end else if (shape < ((cmd == CMD_ADD) ? 60 : 75)) begin
                w.node_id = 8'($urandom_range(0, 3));
                w.msg_id  = 8'($urandom_range(0, 3));
                w.seq_num = 8'($urandom_range(0, 3));
            end
            queue_word(w, (n % 700) == 699);
        end

        while (words_taken != words_queued)
            @(posedge i_clk);
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d adds and %0d checks over %0d cycles", n_adds, n_checks,
                 cycle_count);
        $display("checks found %0d duplicates, %0d hop refreshes, %0d misses", n_dups,
                 n_refresh, n_checks - n_dups - n_refresh);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Release reset.
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

endmodule
